@@ src/sfm_pkg.sv @@
// shared constants and types for the substring first match unit
package sfm_pkg;

  localparam int MAX_PATTERN   = 16;
  localparam int INDEX_BITS    = 16;
  localparam int CHAR_W        = 8;
  localparam int PLEN_REG_W    = 5;
  localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
  localparam int WIN_IDX_W     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PAT_WORD_W    = 64;
  localparam int PAT_WORD_BYTES = PAT_WORD_W / CHAR_W;
  localparam int CFG_INDEX_W   = 2;
  localparam int MATCH_INDEX_W = 16;
  localparam int S_TDATA_W     = 8;
  localparam int M_TDATA_W     = 24;

  typedef logic [CHAR_W-1:0]        char_t;
  typedef logic [LEN_W-1:0]         len_t;
  typedef logic [INDEX_BITS-1:0]    index_t;
  typedef logic [MATCH_INDEX_W-1:0] match_index_t;

  localparam char_t  TERMINATOR = '0;
  localparam index_t IDX_MAX    = '1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic step;
    logic clear;
  } win_ctrl_t;

endpackage

@@ src/sfm_cfg.sv @@
// configuration registers: pattern length and pattern bytes
module sfm_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sfm_pkg::PAT_WORD_W-1:0]      cfg_data,
  output sfm_pkg::len_t                       pat_len,
  output sfm_pkg::char_t                      pat [sfm_pkg::MAX_PATTERN]
);

  logic [sfm_pkg::PLEN_REG_W-1:0] pattern_length;
  logic [sfm_pkg::PAT_WORD_W-1:0] pattern_low;
  logic [sfm_pkg::PAT_WORD_W-1:0] pattern_high;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      pattern_low    <= '0;
      pattern_high   <= '0;
    end else if (cfg_valid) begin
      case (sfm_pkg::cfg_reg_t'(cfg_index))
        sfm_pkg::REG_PATTERN_LENGTH: begin
          pattern_length <= cfg_data[sfm_pkg::PLEN_REG_W-1:0];
        end
        sfm_pkg::REG_PATTERN_LOW: begin
          pattern_low <= cfg_data;
        end
        sfm_pkg::REG_PATTERN_HIGH: begin
          pattern_high <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // lengths above the window depth use the whole window
  always_comb begin
    if (pattern_length > sfm_pkg::PLEN_REG_W'(sfm_pkg::MAX_PATTERN)) begin
      pat_len = sfm_pkg::len_t'(sfm_pkg::MAX_PATTERN);
    end else begin
      pat_len = sfm_pkg::len_t'(pattern_length);
    end
  end

  for (genvar k = 0; k < sfm_pkg::MAX_PATTERN; k++) begin : g_pat
    if (k < sfm_pkg::PAT_WORD_BYTES) begin : g_low
      assign pat[k] = pattern_low[sfm_pkg::CHAR_W*k +: sfm_pkg::CHAR_W];
    end else begin : g_high
      assign pat[k] =
        pattern_high[sfm_pkg::CHAR_W*(k-sfm_pkg::PAT_WORD_BYTES) +: sfm_pkg::CHAR_W];
    end
  end

endmodule

@@ src/sfm_window.sv @@
// character window with fill count and parallel compare against the pattern
module sfm_window (
  input  logic               clk,
  input  logic               rst,
  input  sfm_pkg::win_ctrl_t ctrl,
  input  sfm_pkg::char_t     text_char,
  input  sfm_pkg::len_t      pat_len,
  input  sfm_pkg::char_t     pat [sfm_pkg::MAX_PATTERN],
  output logic               hit
);

  sfm_pkg::char_t window     [sfm_pkg::MAX_PATTERN];
  sfm_pkg::char_t window_next[sfm_pkg::MAX_PATTERN];
  sfm_pkg::len_t  fill;
  sfm_pkg::len_t  fill_next;

  // newest character at entry 0
  always_comb begin
    window_next[0] = text_char;
    for (int j = 1; j < sfm_pkg::MAX_PATTERN; j++) begin
      window_next[j] = window[j-1];
    end
    if (fill < sfm_pkg::len_t'(sfm_pkg::MAX_PATTERN)) begin
      fill_next = fill + sfm_pkg::len_t'(1);
    end else begin
      fill_next = fill;
    end
  end

  // entry j pairs with pattern byte len-1-j
  always_comb begin
    sfm_pkg::len_t k;
    logic          eq;
    k  = '0;
    eq = 1'b1;
    for (int j = 0; j < sfm_pkg::MAX_PATTERN; j++) begin
      k = pat_len - sfm_pkg::len_t'(1) - sfm_pkg::len_t'(j);
      if ((sfm_pkg::len_t'(j) < pat_len) &&
          (window_next[j] != pat[k[sfm_pkg::WIN_IDX_W-1:0]])) begin
        eq = 1'b0;
      end
    end
    hit = eq && (fill_next >= pat_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctrl.clear) begin
      fill <= '0;
    end else if (ctrl.step) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      window <= window_next;
    end
  end

endmodule

@@ src/substring_first_match_unit.sv @@
// top level: input register, match control and result register
// a character is held in the input register and its result in the result register
// throughput: one character per cycle while the result output is not stalled;
// each step is the window shift and parallel compare against all pattern bytes
// reset: clears the pattern registers, the window fill, the character count
// and all valid flags; the window bytes themselves are not cleared
module substring_first_match_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sfm_pkg::S_TDATA_W-1:0]       s_tdata,   // text_char
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [sfm_pkg::M_TDATA_W-1:0]       m_tdata,   // found, match_index, index_saturated, zero pad
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sfm_pkg::PAT_WORD_W-1:0]      cfg_data
);

  sfm_pkg::len_t       pat_len;
  sfm_pkg::char_t      pat [sfm_pkg::MAX_PATTERN];

  logic                s1_valid;
  sfm_pkg::char_t      s1_char;

  sfm_pkg::index_t     chars_seen;
  sfm_pkg::index_t     chars_seen_next;
  logic                answered;
  logic                answered_next;
  logic                count_saturated;
  logic                count_saturated_next;

  logic                adv;
  logic                hit;
  sfm_pkg::win_ctrl_t  wctrl;

  logic                res_valid;
  logic                res_found;
  sfm_pkg::index_t     res_index;
  logic                res_sat;

  logic                found;
  sfm_pkg::match_index_t match_index;
  logic                index_saturated;

  sfm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pat_len   (pat_len),
    .pat       (pat)
  );

  sfm_window u_window (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (wctrl),
    .text_char (s1_char),
    .pat_len   (pat_len),
    .pat       (pat),
    .hit       (hit)
  );

  assign adv      = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_char <= s_tdata[sfm_pkg::CHAR_W-1:0];
    end
  end

  always_comb begin
    logic is_term;
    is_term              = (s1_char == sfm_pkg::TERMINATOR);
    wctrl                = '0;
    res_valid            = 1'b0;
    res_found            = 1'b0;
    res_index            = '0;
    res_sat              = 1'b0;
    chars_seen_next      = chars_seen;
    answered_next        = answered;
    count_saturated_next = count_saturated;

    if (!answered && (pat_len == '0)) begin
      // empty pattern matches at the start
      res_valid = 1'b1;
      res_found = 1'b1;
      if (is_term) begin
        wctrl.clear          = 1'b1;
        chars_seen_next      = '0;
        count_saturated_next = 1'b0;
      end else begin
        answered_next = 1'b1;
      end
    end else if (is_term) begin
      res_valid            = !answered;
      res_sat              = count_saturated;
      wctrl.clear          = 1'b1;
      chars_seen_next      = '0;
      answered_next        = 1'b0;
      count_saturated_next = 1'b0;
    end else if (!answered) begin
      wctrl.step = 1'b1;
      if (chars_seen == sfm_pkg::IDX_MAX) begin
        count_saturated_next = 1'b1;
      end else begin
        chars_seen_next = chars_seen + sfm_pkg::index_t'(1);
      end
      if (hit) begin
        res_valid     = 1'b1;
        res_found     = 1'b1;
        answered_next = 1'b1;
        if (count_saturated) begin
          res_index = sfm_pkg::IDX_MAX;
          res_sat   = 1'b1;
        end else begin
          res_index = chars_seen + sfm_pkg::index_t'(1) - sfm_pkg::index_t'(pat_len);
        end
      end
    end

    if (!adv) begin
      wctrl                = '0;
      res_valid            = 1'b0;
      chars_seen_next      = chars_seen;
      answered_next        = answered;
      count_saturated_next = count_saturated;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chars_seen      <= '0;
      answered        <= 1'b0;
      count_saturated <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      chars_seen      <= chars_seen_next;
      answered        <= answered_next;
      count_saturated <= count_saturated_next;
      if (adv) begin
        m_tvalid <= res_valid;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      found           <= res_found;
      match_index     <= sfm_pkg::match_index_t'(res_index);
      index_saturated <= res_sat;
    end
  end

  assign m_tdata = sfm_pkg::M_TDATA_W'({index_saturated, match_index, found});

  // a terminator always leaves a cleared string state
  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    adv && (s1_char == sfm_pkg::TERMINATOR) |=> !answered && (chars_seen == '0)
      && !count_saturated)
    else $error("state not cleared after terminator");

  // the count only saturates at its maximum
  a_sat_at_max: assert property (@(posedge clk) disable iff (rst)
    count_saturated |-> chars_seen == sfm_pkg::IDX_MAX)
    else $error("saturation flag without full count");

  // a not found result carries index zero
  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !found |-> match_index == '0)
    else $error("not found result with nonzero index");

endmodule

@@ bench/substring_first_match_unit_test.sv @@
// self-checking bench for substring_first_match_unit: directed table, random strings, saturation
`timescale 1ns / 100ps

module substring_first_match_unit_test;
  import sfm_pkg::*;

  localparam int unsigned LIMIT       = 2_000_000;
  localparam int unsigned DRAIN       = 6;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned PHASES      = 14;
  localparam int unsigned PHASE_CHARS = 32;
  localparam logic [63:0] LONG_PATTERN = 64'h5A59_5857;
  localparam char_t       LONG_LEAD    = 8'h57;
  localparam char_t       ALPHA_BASE   = 8'h61;

  typedef enum logic {ROW_REG, ROW_CHAR} row_kind_t;
  typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_HIT} exp_kind_t;

  typedef struct packed {
    logic         sat;
    match_index_t idx;
    logic         found;
  } search_result_t;

  typedef struct packed {
    row_kind_t    kind;
    cfg_reg_t     addr;
    logic [63:0]  value;
    exp_kind_t    check;
    logic         found;
    match_index_t idx;
    logic         sat;
  } dir_row_t;

  localparam int unsigned N_ROWS = 31;
  localparam dir_row_t DIRECTED_ROWS [0:N_ROWS-1] = '{
    // empty pattern after reset
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h78, EXP_HIT,  1'b1, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h79, EXP_NONE, 1'b0, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h00, EXP_NONE, 1'b0, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h00, EXP_HIT,  1'b1, 16'd0, 1'b0},
    // pattern "abc", unused high bytes all ones
    '{ROW_REG,  REG_PATTERN_LENGTH, 64'd3, EXP_NONE, 1'b0, 16'd0, 1'b0},
    '{ROW_REG,  REG_PATTERN_LOW, 64'h63_6261, EXP_NONE, 1'b0, 16'd0, 1'b0},
    '{ROW_REG,  REG_PATTERN_HIGH, '1, EXP_NONE, 1'b0, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h61, EXP_PREDICT, 1'b0, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h62, EXP_PREDICT, 1'b0, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h63, EXP_HIT,  1'b1, 16'd0, 1'b0},
    // ignored after a match
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h7a, EXP_NONE, 1'b0, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h00, EXP_NONE, 1'b0, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h78, EXP_PREDICT, 1'b0, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h61, EXP_PREDICT, 1'b0, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h62, EXP_PREDICT, 1'b0, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h63, EXP_HIT,  1'b1, 16'd1, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h00, EXP_NONE, 1'b0, 16'd0, 1'b0},
    // not found
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h61, EXP_PREDICT, 1'b0, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h62, EXP_PREDICT, 1'b0, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h00, EXP_HIT,  1'b0, 16'd0, 1'b0},
    // extreme character values
    '{ROW_REG,  REG_PATTERN_LENGTH, 64'd1, EXP_NONE, 1'b0, 16'd0, 1'b0},
    '{ROW_REG,  REG_PATTERN_LOW, '1, EXP_NONE, 1'b0, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h01, EXP_NONE, 1'b0, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'hff, EXP_HIT,  1'b1, 16'd1, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'hff, EXP_NONE, 1'b0, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h00, EXP_NONE, 1'b0, 16'd0, 1'b0},
    // zero byte inside the pattern never matches
    '{ROW_REG,  REG_PATTERN_LENGTH, 64'd2, EXP_NONE, 1'b0, 16'd0, 1'b0},
    '{ROW_REG,  REG_PATTERN_LOW, 64'h0041, EXP_NONE, 1'b0, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h41, EXP_PREDICT, 1'b0, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h41, EXP_NONE, 1'b0, 16'd0, 1'b0},
    '{ROW_CHAR, REG_PATTERN_LENGTH, 64'h00, EXP_HIT,  1'b0, 16'd0, 1'b0}
  };

  localparam int unsigned PHASE_LENGTHS [0:PHASES-1] =
    '{1, 16, 31, 2, 0, 5, 17, 3, 8, 16, 4, 1, 31, 2};

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [S_TDATA_W-1:0]    s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [M_TDATA_W-1:0]    m_tdata;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [PAT_WORD_W-1:0]   cfg_data = '0;

  // search state mirrored by the bench
  logic [PLEN_REG_W-1:0]   plen_reg;
  logic [PAT_WORD_W-1:0]   pat_lo;
  logic [PAT_WORD_W-1:0]   pat_hi;
  char_t                   win [MAX_PATTERN];
  index_t                  seen;
  int unsigned             fill;
  bit                      answered;
  bit                      saturated;

  search_result_t          pending_hits [$];
  int unsigned             send_idle_pct;
  int unsigned             recv_stall_pct = 0;
  int unsigned             hold_req = 0;
  int unsigned             hold_taken = 0;
  int unsigned             hold_left = 0;
  int unsigned             cycles = 0;
  int unsigned             chars_sent;
  int unsigned             results_seen = 0;
  int unsigned             mismatches = 0;

  substring_first_match_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // text_char
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // found, match_index, index_saturated, zero pad
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_hits.size());
      $display("substring_first_match_unit test failed");
      $finish;
    end
  end

  function automatic char_t pat_byte(input int unsigned k);
    return (k < 8) ? pat_lo[8*k +: 8] : pat_hi[8*(k-8) +: 8];
  endfunction

  function automatic char_t pick_char(input int unsigned alpha);
    return (alpha == 0) ? char_t'($urandom_range(1, 255))
                        : char_t'(ALPHA_BASE + $urandom_range(alpha - 1));
  endfunction

  task automatic clear_search();
    foreach (win[i]) win[i] = '0;
    seen      = '0;
    fill      = 0;
    answered  = 1'b0;
    saturated = 1'b0;
  endtask

  // advance the mirrored search by one character
  task automatic search_step(input char_t c, output bit hit, output search_result_t r);
    int unsigned len;
    index_t      pos;
    bit          sat_before;
    bit          all_equal;
    hit = 1'b0;
    r   = '0;
    len = (plen_reg > MAX_PATTERN) ? MAX_PATTERN : plen_reg;
    if (!answered && len == 0) begin
      hit     = 1'b1;
      r.found = 1'b1;
      if (c == TERMINATOR) clear_search();
      else answered = 1'b1;
      return;
    end
    if (c == TERMINATOR) begin
      if (!answered) begin
        hit   = 1'b1;
        r.sat = saturated;
      end
      clear_search();
      return;
    end
    if (answered) return;
    pos        = seen;
    sat_before = saturated;
    if (seen == IDX_MAX) saturated = 1'b1;
    else seen = seen + 1'b1;
    for (int i = MAX_PATTERN - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = c;
    if (fill < MAX_PATTERN) fill++;
    if (fill < len) return;
    all_equal = 1'b1;
    for (int unsigned i = 0; i < len; i++)
      if (win[len-1-i] != pat_byte(i)) all_equal = 1'b0;
    if (!all_equal) return;
    answered = 1'b1;
    hit      = 1'b1;
    r.found  = 1'b1;
    if (sat_before) begin
      r.idx = '1;
      r.sat = 1'b1;
    end else begin
      r.idx = match_index_t'(pos + 1 - len);
    end
  endtask

  task automatic send_char(input char_t c, input bit fixed, input bit fixed_hit,
                           input search_result_t fixed_r);
    bit             hit;
    search_result_t r;
    s_tdata  <= c;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    search_step(c, hit, r);
    if (fixed) begin
      hit = fixed_hit;
      r   = fixed_r;
    end
    if (hit) pending_hits.push_back(r);
    chars_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // stop sending and wait until the block has nothing left in flight
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_hits.size() != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t a, input logic [63:0] v);
    cfg_index <= a;
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (a)
      REG_PATTERN_LENGTH: plen_reg = v[PLEN_REG_W-1:0];
      REG_PATTERN_LOW:    pat_lo   = v;
      REG_PATTERN_HIGH:   pat_hi   = v;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one string: mostly alphabet text with the pattern or a broken prefix, some noise
  task automatic send_text(input int unsigned alpha);
    int unsigned n, at, choice, used, plen;
    bit          embed;
    used   = (plen_reg > MAX_PATTERN) ? MAX_PATTERN : plen_reg;
    n      = $urandom_range(0, 24);
    choice = $urandom_range(99);
    if (choice < 15) begin
      repeat (n) send_char(char_t'($urandom_range(1, 255)), 1'b0, 1'b0, '0);
    end else begin
      embed = (choice < 85) && (used != 0);
      plen  = (choice < 70) ? used : $urandom_range(0, (used == 0) ? 0 : used - 1);
      at    = $urandom_range(0, n);
      for (int unsigned k = 0; k <= n; k++) begin
        if (embed && k == at)
          for (int unsigned j = 0; j < plen; j++) send_char(pat_byte(j), 1'b0, 1'b0, '0);
        if (k < n) send_char(pick_char(alpha), 1'b0, 1'b0, '0);
      end
    end
    send_char(TERMINATOR, 1'b0, 1'b0, '0);
  endtask

  // long string of filler without the pattern lead, to drive the index into saturation
  task automatic send_long(input int unsigned filler, input bit with_pattern);
    char_t c;
    for (int unsigned k = 0; k < filler; k++) begin
      do c = char_t'($urandom_range(1, 255)); while (c == LONG_LEAD);
      send_char(c, 1'b0, 1'b0, '0);
    end
    if (with_pattern)
      for (int unsigned k = 0; k < 4; k++)
        send_char(LONG_PATTERN[8*k +: 8], 1'b0, 1'b0, '0);
    send_char(TERMINATOR, 1'b0, 1'b0, '0);
  endtask

  // result side: check each word, random stalls, long hold-off on request
  always @(posedge clk) begin : collect
    search_result_t got;
    search_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.found = m_tdata[0];
      got.idx   = m_tdata[16:1];
      got.sat   = m_tdata[17];
      results_seen++;
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0d: unexpected result found=%0b idx=%0d sat=%0b",
                   cycles, got.found, got.idx, got.sat);
      end else begin
        want = pending_hits.pop_front();
        if (got.found != want.found || got.idx != want.idx || got.sat != want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0d: expected found=%0b idx=%0d sat=%0b, got found=%0b idx=%0d sat=%0b",
                     cycles, want.found, want.idx, want.sat, got.found, got.idx, got.sat);
        end
      end
    end
    if (hold_req != hold_taken) begin
      hold_taken <= hold_req;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    dir_row_t       row;
    search_result_t typed;
    int unsigned    len, alpha, goal, used;
    logic [63:0]    lo, hi;
    char_t          b;
    bit             paused;
    plen_reg      = '0;
    pat_lo        = '0;
    pat_hi        = '0;
    clear_search();
    send_idle_pct = 0;
    chars_sent    = 0;
    paused        = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int unsigned i = 0; i < N_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_REG) begin
        settle();
        write_reg(row.addr, row.value);
      end else begin
        typed.found = row.found;
        typed.idx   = row.idx;
        typed.sat   = row.sat;
        send_char(row.value[7:0], row.check != EXP_PREDICT, row.check == EXP_HIT, typed);
      end
    end

    // empty pattern: every terminator answers, while the output is held off
    settle();
    write_reg(REG_PATTERN_LENGTH, '0);
    hold_req <= hold_req + 1;
    repeat (40) send_char(TERMINATOR, 1'b0, 1'b0, '0);

    for (int unsigned p = 0; p < PHASES; p++) begin
      settle();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 68; end
        default: begin send_idle_pct = 14; recv_stall_pct <= 14; end
      endcase
      len   = PHASE_LENGTHS[p];
      alpha = (p % 5 == 3) ? 0 : $urandom_range(2, 4);
      for (int unsigned k = 0; k < 16; k++) begin
        b = pick_char(alpha);
        if (k < 8) lo[8*k +: 8] = b;
        else hi[8*(k-8) +: 8] = b;
      end
      used = (len > MAX_PATTERN) ? MAX_PATTERN : len;
      if (used != 0 && $urandom_range(9) == 0) begin
        b = char_t'($urandom_range(0, used - 1));
        if (b < 8) lo[8*b +: 8] = '0;
        else hi[8*(b-8) +: 8] = '0;
      end
      write_reg(REG_PATTERN_LENGTH, 64'(len));
      write_reg(REG_PATTERN_LOW, lo);
      write_reg(REG_PATTERN_HIGH, hi);
      goal = chars_sent + PHASE_CHARS;
      while (chars_sent < goal) begin
        send_text(alpha);
        if (p == 6 && !paused && chars_sent + 16 >= goal) begin
          settle();
          paused = 1'b1;
        end
      end
    end

    // index saturation: match ending at the last index, match past it, no match
    settle();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    write_reg(REG_PATTERN_LENGTH, 64'd4);
    write_reg(REG_PATTERN_LOW, LONG_PATTERN);
    write_reg(REG_PATTERN_HIGH, '0);
    send_long(32'(IDX_MAX) - 3, 1'b1);
    send_long(32'(IDX_MAX) + 5, 1'b1);
    send_long(32'(IDX_MAX) + 2, 1'b0);

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_hits.size() != 0);
    repeat (DRAIN) @(posedge clk);
    $display("sent %0d characters, checked %0d results, %0d mismatches, %0d cycles",
             chars_sent, results_seen, mismatches, cycles);
    $display("covered empty, oversize and zero-byte patterns, output hold-off, index saturation");
    if (mismatches == 0) begin
      $display("substring_first_match_unit test passed");
    end else begin
      $display("substring_first_match_unit test failed");
    end
    $finish;
  end

endmodule
